// ===== src/swmf_pkg.sv =====
// shared types and constants of the sliding window median filter
`timescale 1ns / 1ps

package swmf_pkg;

    localparam int DATA_W = 16;
    localparam int CFG_W  = 15;
    localparam int STEP_W = $clog2(DATA_W);

    localparam logic [CFG_W-1:0] MAXD_RESET = 15'd600;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [CFG_W-1:0]         maxd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // control from the sequencer to the window and the rank selector
    typedef struct packed
    {
        logic load;
        logic step;
        logic first;
    } ctrl_t;

endpackage

// ===== src/swmf_if.sv =====
// handshake channel interfaces of the sliding window median filter
`timescale 1ns / 1ps

interface swmf_in_if;
    logic               valid;
    logic               ready;
    swmf_pkg::sample_t  reading;

    modport source (output valid, output reading, input ready);
    modport sink   (input valid, input reading, output ready);
endinterface

interface swmf_out_if;
    logic               valid;
    logic               ready;
    swmf_pkg::sample_t  filtered_distance;

    modport source (output valid, output filtered_distance, input ready);
    modport sink   (input valid, input filtered_distance, output ready);
endinterface

interface swmf_cfg_if;
    logic               valid;
    logic               ready;
    swmf_pkg::maxd_t    clip_limit;

    modport source (output valid, output clip_limit, input ready);
    modport sink   (input valid, input clip_limit, output ready);
endinterface

// ===== src/swmf_window.sv =====
// sample window shift registers with clip on insert and bit rotation for scanning
`timescale 1ns / 1ps

module swmf_window #(
    parameter int WINDOW = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swmf_pkg::ctrl_t     ctrl,
    input  swmf_pkg::sample_t   reading,
    input  swmf_pkg::maxd_t     clip_limit,
    output logic [WINDOW-1:0]   column
);
    import swmf_pkg::*;

    sample_t win_reg [WINDOW];
    sample_t limit;
    sample_t clipped;

    assign limit   = sample_t'({1'b0, clip_limit});
    assign clipped = (reading > limit) ? limit : reading;

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++)
        begin : g_entry
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    win_reg[i] <= sample_t'({1'b0, MAXD_RESET});
                end
                else if (ctrl.load)
                begin
                    // oldest entry drops off the tail
                    if (i == 0)
                    begin
                        win_reg[i] <= clipped;
                    end
                    else
                    begin
                        win_reg[i] <= win_reg[(i == 0) ? 0 : i - 1];
                    end
                end
                else if (ctrl.step)
                begin
                    win_reg[i] <= {win_reg[i][DATA_W-2:0], win_reg[i][DATA_W-1]};
                end
            end

            assign column[i] = win_reg[i][DATA_W-1];
        end
    endgenerate

endmodule

// ===== src/swmf_select.sv =====
// bit-serial rank selection of the two middle window values, msb first
`timescale 1ns / 1ps

module swmf_select #(
    parameter int WINDOW = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swmf_pkg::ctrl_t     ctrl,
    input  logic [WINDOW-1:0]   column,
    output swmf_pkg::sample_t   lo_value,
    output swmf_pkg::sample_t   hi_value
);
    import swmf_pkg::*;

    localparam int CW = $clog2(WINDOW + 1);

    sample_t value [2];
    logic [WINDOW-1:0] key;

    // sign bit inverted so that signed order becomes unsigned order
    assign key = column ^ {WINDOW{ctrl.first}};

    genvar t;
    generate
        for (t = 0; t < 2; t++)
        begin : g_track
            localparam int RANK = (t == 0) ? (WINDOW - 1) / 2 : WINDOW / 2;

            logic [WINDOW-1:0] act_reg;
            logic [WINDOW-1:0] act_next;
            logic [CW-1:0]     rank_reg;
            logic [CW-1:0]     rank_next;
            sample_t           val_reg;
            sample_t           val_next;
            logic [WINDOW-1:0] zeros;
            logic [CW-1:0]     zero_cnt;
            logic              bit_sel;

            assign zeros    = act_reg & ~key;
            assign zero_cnt = CW'($countones(zeros));

            always_comb
            begin
                act_next  = act_reg;
                rank_next = rank_reg;
                val_next  = val_reg;
                bit_sel   = 1'b0;
                if (ctrl.load)
                begin
                    act_next  = {WINDOW{1'b1}};
                    rank_next = CW'(RANK);
                end
                else if (ctrl.step)
                begin
                    if (zero_cnt > rank_reg)
                    begin
                        act_next = zeros;
                    end
                    else
                    begin
                        bit_sel   = 1'b1;
                        act_next  = act_reg & key;
                        rank_next = rank_reg - zero_cnt;
                    end
                    val_next = {val_reg[DATA_W-2:0], bit_sel ^ ctrl.first};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    act_reg  <= '0;
                    rank_reg <= '0;
                end
                else
                begin
                    act_reg  <= act_next;
                    rank_reg <= rank_next;
                end
            end

            always_ff @(posedge clk)
            begin
                val_reg <= val_next;
            end

            assign value[t] = val_reg;
        end
    endgenerate

    assign lo_value = value[0];
    assign hi_value = value[1];

endmodule

// ===== src/sliding_window_median_filter.sv =====
// top level of the sliding window median filter: sequencer, config register, output register
//
//  channel   | role   | payload                     | transaction
//  ----------+--------+-----------------------------+------------------------------
//  samples   | sink   | reading, 16 bit signed      | one raw distance reading
//  medians   | source | filtered_distance, 16 bit   | median of window after insert
//  cfg       | sink   | clip_limit, 15 bit          | write of the clip register
//
//  an accepted reading is clipped and shifted into the window in its accept cycle
//  the window is then scanned one bit column per cycle over all data bits, msb first,
//  and the finish state forms the median; the next reading is accepted only in idle
//  a result waiting on medians holds the block in its finish state until taken
//  reset fills the window with 600 and sets clip_limit to 600; cfg is always ready
`timescale 1ns / 1ps

module sliding_window_median_filter #(
    parameter int WINDOW = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    swmf_in_if.sink      samples,
    swmf_out_if.source   medians,
    swmf_cfg_if.sink     cfg
);
    import swmf_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_cnt_reg;
    logic [STEP_W-1:0]   step_cnt_next;
    maxd_t               clip_limit_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    sample_t             out_data_reg;
    logic                out_load;
    ctrl_t               ctrl;
    logic [WINDOW-1:0]   column;
    sample_t             lo_value;
    sample_t             hi_value;
    logic signed [DATA_W:0] pair_sum;
    sample_t             median;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_limit_reg <= MAXD_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            clip_limit_reg <= cfg.clip_limit;
        end
    end

    swmf_window #(.WINDOW(WINDOW)) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .reading      (samples.reading),
        .clip_limit   (clip_limit_reg),
        .column       (column)
    );

    swmf_select #(.WINDOW(WINDOW)) u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .column   (column),
        .lo_value (lo_value),
        .hi_value (hi_value)
    );

    // mean of the two middle values, truncated toward zero
    assign pair_sum = {lo_value[DATA_W-1], lo_value} + {hi_value[DATA_W-1], hi_value};
    assign median   = pair_sum[DATA_W:1]
                    + sample_t'({{(DATA_W-1){1'b0}}, pair_sum[DATA_W] & pair_sum[0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= median;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        ctrl           = '0;
        out_load       = 1'b0;
        samples.ready  = 1'b0;
        out_valid_next = out_valid_reg && !medians.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid)
                begin
                    ctrl.load     = 1'b1;
                    step_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.step     = 1'b1;
                ctrl.first    = (step_cnt_reg == '0);
                step_cnt_next = step_cnt_reg + STEP_W'(1);
                if (step_cnt_reg == STEP_W'(DATA_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || medians.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign medians.valid             = out_valid_reg;
    assign medians.filtered_distance = out_data_reg;

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> (state_reg == ST_SCAN && step_cnt_reg == '0))
        else $error("accepted transaction did not start a scan");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && step_cnt_reg == STEP_W'(DATA_W - 1)) |=>
        (state_reg == ST_FINISH))
        else $error("scan did not end after the last bit column");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !medians.ready) |=>
        (state_reg == ST_FINISH))
        else $error("result overran a pending transaction");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (lo_value <= hi_value))
        else $error("lower middle value above upper middle value");

    a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("output loaded outside the finish cycle");

endmodule

// ===== verif/tb_sliding_window_median_filter.sv =====
// testbench of the sliding window median filter: scoreboard class and handshake drivers
`timescale 1ns / 1ps

module tb_sliding_window_median_filter;

    import swmf_pkg::*;

    localparam int WINDOW      = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 108;

    class median_tracker;
        sample_t     window[WINDOW];
        int unsigned slot;
        maxd_t       maxd;
        sample_t     expected_medians[$];
        int          failures;
        int          reports;

        function new();
            for (int i = 0; i < WINDOW; i++)
            begin
                window[i] = sample_t'(MAXD_RESET);
            end
            slot     = 0;
            maxd     = MAXD_RESET;
            failures = 0;
            reports  = 0;
        endfunction

        function void set_clip_limit(maxd_t value);
            maxd = value;
        endfunction

        function int pending();
            return expected_medians.size();
        endfunction

        function void flag(string msg);
            failures++;
            if (reports < 10)
            begin
                reports++;
                $display("%s", msg);
            end
        endfunction

        // clip, overwrite the oldest entry, then rank the window
        function void note_reading(sample_t reading);
            int value;
            int lim;
            int key;
            int j;
            int med;
            int sorted[WINDOW];
            value = reading;
            lim   = maxd;
            if (value > lim)
            begin
                value = lim;
            end
            window[slot] = sample_t'(value);
            slot = (slot + 1) % WINDOW;
            for (int i = 0; i < WINDOW; i++)
            begin
                sorted[i] = window[i];
            end
            for (int i = 1; i < WINDOW; i++)
            begin
                key = sorted[i];
                j   = i - 1;
                while (j >= 0 && sorted[j] > key)
                begin
                    sorted[j + 1] = sorted[j];
                    j--;
                end
                sorted[j + 1] = key;
            end
            if (WINDOW % 2 == 0)
            begin
                med = (sorted[WINDOW / 2] + sorted[WINDOW / 2 - 1]) / 2;
            end
            else
            begin
                med = sorted[WINDOW / 2];
            end
            expected_medians.push_back(sample_t'(med));
        endfunction

        function void check_median(sample_t got);
            sample_t want;
            if (expected_medians.size() == 0)
            begin
                flag($sformatf("median transaction %0d with none expected", got));
            end
            else
            begin
                want = expected_medians.pop_front();
                if (want !== got)
                begin
                    flag($sformatf("median mismatch: expected %0d, actual %0d", want, got));
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    bit   no_idle;

    median_tracker tracker;

    swmf_in_if  samples_ch();
    swmf_out_if medians_ch();
    swmf_cfg_if cfg_ch();

    sliding_window_median_filter #(
        .WINDOW (WINDOW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .medians (medians_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sliding_window_median_filter test failed");
            $finish;
        end
    end

    // entered and left at a falling edge
    task automatic send_reading(input sample_t value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid   <= 1'b1;
        samples_ch.reading <= value;
        do
        begin
            @(posedge clk);
        end
        while (!samples_ch.ready);
        tracker.note_reading(value);
        @(negedge clk);
    endtask

    task automatic drain();
        samples_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (tracker.pending() != 0);
    endtask

    task automatic write_clip_limit(input maxd_t value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.clip_limit <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        tracker.set_clip_limit(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic collect_medians();
        int stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                medians_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            medians_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!medians_ch.valid);
            tracker.check_median(medians_ch.filtered_distance);
            @(negedge clk);
        end
    endtask

    initial
    begin
        sample_t prev;
        sample_t value;
        maxd_t   lim;
        int      kind;

        clk                 = 1'b0;
        rst_n               = 1'b0;
        cycle_count         = 0;
        no_idle             = 1'b0;
        samples_ch.valid    = 1'b0;
        samples_ch.reading  = '0;
        medians_ch.ready    = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.clip_limit   = '0;
        tracker             = new();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        fork
            collect_medians();
        join_none

        // window still holds the reset fill, clip at its reset value
        send_reading(-16'sd32768);
        send_reading(16'sd32767);
        send_reading(16'sd0);
        send_reading(-16'sd1);
        send_reading(16'sd600);
        send_reading(16'sd601);
        send_reading(16'sd599);
        send_reading(16'sh5555);
        send_reading(sample_t'(16'hAAAA));
        drain();

        // lowest clip: every positive reading becomes zero
        write_clip_limit(15'd0);
        send_reading(16'sd1);
        send_reading(-16'sd1);
        send_reading(16'sd32767);
        send_reading(16'sd0);
        send_reading(-16'sd32768);
        drain();

        // highest clip: nothing is ever clipped
        write_clip_limit(15'h7FFF);
        send_reading(16'sd32767);
        send_reading(16'sd32766);
        send_reading(-16'sd32768);
        send_reading(16'sd32767);
        send_reading(16'sd32767);
        send_reading(16'sd32767);
        drain();

        prev = '0;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: lim = 15'd1;
                1: lim = 15'h7FFF;
                3: lim = 15'd0;
                5: lim = MAXD_RESET;
                default: lim = maxd_t'($urandom_range(0, 32767));
            endcase
            write_clip_limit(lim);
            no_idle = (p % 3 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2, 3: value = sample_t'($urandom);
                    4, 5: value = sample_t'(int'(lim) + $urandom_range(0, 8) - 4);
                    6: value = sample_t'(-$urandom_range(1, 300));
                    7: value = prev;
                    8:
                    begin
                        case ($urandom_range(0, 2))
                            0: value = -16'sd32768;
                            1: value = 16'sd32767;
                            default: value = 16'sd0;
                        endcase
                    end
                    default: value = sample_t'($urandom_range(0, lim));
                endcase
                send_reading(value);
                prev = value;
            end
            drain();
        end

        no_idle = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
        begin
            $display("sliding_window_median_filter test passed");
        end
        else
        begin
            $display("sliding_window_median_filter test failed");
        end
        $finish;
    end

endmodule
